>>> rtl/fsbc_pkg.sv
// Shared types, codes and helpers for the floppy stepper and bit controller.
// No dependencies; imported by the top level.
package fsbc_pkg;

  // Bus command codes carried in the low bits of in_tdata.
  typedef enum logic [2:0] {
    CMD_LATCH     = 3'd0,
    CMD_DATA_RD   = 3'd1,
    CMD_POLL      = 3'd2,
    CMD_PROTECT   = 3'd3,
    CMD_HOST_LOAD = 3'd4,
    CMD_HOST_READ = 3'd5
  } cmd_t;

  // Source of read_data, resolved in the second stage.
  typedef enum logic [1:0] {
    RD_CONST = 2'd0,
    RD_MEM   = 2'd1,
    RD_SHIFT = 2'd2
  } rd_sel_t;

  // Shift register operation, resolved in the second stage.
  typedef enum logic [1:0] {
    SW_KEEP  = 2'd0,
    SW_SHIFT = 2'd1,
    SW_LOAD  = 2'd2
  } sw_op_t;

  // Drive select codes.
  localparam logic [1:0] SEL_DRIVE0 = 2'd0;
  localparam logic [1:0] SEL_DRIVE1 = 2'd1;
  localparam logic [1:0] SEL_NONE   = 2'd2;

  // Latch bit positions.
  localparam int LATCH_SEL0 = 4;
  localparam int LATCH_FLUX = 5;
  localparam int LATCH_GATE = 6;
  localparam int LATCH_SEL1 = 7;

  // Stepper directions, as phase offsets.
  localparam logic [1:0] DIR_OUT = 2'd1;
  localparam logic [1:0] DIR_IN  = 2'd3;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;
  localparam logic [7:0] BUS_IDLE      = 8'hff;
  localparam logic [7:0] FLAG_SET      = 8'h80;
  localparam logic [7:0] FLAG_CLEAR    = 8'h00;

  // Byte from the odd cell positions (even bit indexes) of the shift word.
  function automatic logic [7:0] decode_cells(input logic [15:0] w);
    logic [7:0] v;
    v = '0;
    for (int k = 0; k < 8; k++) begin
      v[k] = w[2*k];
    end
    return v;
  endfunction

  // True when exactly phase n is on now and phase n+dir was on before.
  function automatic logic stepped(input logic [7:0] now, input logic [7:0] prev,
                                   input logic [1:0] dir);
    logic hit;
    logic [1:0] idx;
    hit = 1'b0;
    for (int n = 0; n < 4; n++) begin
      idx = 2'(n) + dir;
      if (now[3:0] == (4'b0001 << n) && prev[idx]) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

endpackage

>>> rtl/fsbc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module fsbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 3172
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/floppy_stepper_and_bit_controller.sv
// Floppy stepper and bit-serial controller, top level.
// Depends on fsbc_pkg and fsbc_ram.
//
// Usage: each request on the in_ stream is one CPU bus access (latch write,
// data read, poll, protect read, host buffer load/read). Every request
// yields exactly one result on the out_ stream: the bus read value plus
// load/store requests for the host that handles the disk image.
// cfg_ writes the two write-protect bits; write only while idle.
//
// Throughput: one request per cycle, sustained, as long as out_tready is
// high. A request is registered into stage 1 (s1_r) and then into the
// output register. Stage 1 updates the stepper, bit counters and buffer
// pointers and issues the track buffer read; stage 2 takes the registered
// RAM data, updates the shift word, writes the buffer and builds the
// result into the output register.
// Buffer writes land in stage 2; a stage-1 read of the same entry in the
// same cycle is served from a forwarding register.
//
// Reset (rst_n low, synchronous): both drives at half-track HT_MAX, no drive
// selected, bit counter at BITS_PER_BYTE, other counters cleared, protect
// bits set. Track buffer not cleared; entries undefined until written.
// Stall: with the output register full and out_tready low, in_tready drops
// and the whole pipe holds, RAM read data included.
module floppy_stepper_and_bit_controller
  import fsbc_pkg::*;
#(
  parameter int TRACK_BYTES    = 3172,
  parameter int MAX_HALF_TRACK = 80
) (
  input  logic        clk,
  input  logic        rst_n,
  // cmd[2:0], bus_data[10:3], buffer_index[22:11], zero pad [23]
  input  logic [23:0] in_tdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // read_data[7:0], load_request[8], store_request[9], request_drive[10],
  // request_track[16:11], store_start[28:17], store_count[40:29], pad [47:41]
  output logic [47:0] out_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic        cfg_data
);

  localparam int AW = $clog2(TRACK_BYTES);
  localparam int CW = $clog2(TRACK_BYTES + 1);
  localparam int HW = $clog2(MAX_HALF_TRACK + 1);
  localparam logic [AW-1:0] BP_LAST = AW'(TRACK_BYTES - 1);
  localparam logic [CW-1:0] WC_FULL = CW'(TRACK_BYTES);
  localparam logic [HW-1:0] HT_MAX  = HW'(MAX_HALF_TRACK);
  localparam logic [12:0]   IDX_END = 13'(TRACK_BYTES);

  // Work handed from stage 1 to stage 2.
  typedef struct packed {
    rd_sel_t       rd_sel;
    logic [7:0]    rd_const;
    logic [3:0]    shamt;
    sw_op_t        sw_op;
    logic          flux;
    logic          mem_we;
    logic          wsrc_decode;
    logic [AW-1:0] waddr;
    logic [7:0]    host_byte;
    logic          load;
    logic          store;
    logic          req_drive;
    logic [5:0]    req_track;
    logic [11:0]   store_start;
    logic [11:0]   store_count;
  } s1_t;

  // Control state.
  logic          prot0_r, prot1_r;
  logic [HW-1:0] ht_r [2];
  logic [HW-1:0] ht_nxt [2];
  logic [1:0]    sel_r, sel_nxt;
  logic [7:0]    prev_r, prev_nxt;
  logic [3:0]    bl_r, bl_nxt;
  logic          ep_r, ep_nxt;
  logic          rdy_r, rdy_nxt;
  logic [AW-1:0] bp_r, bp_nxt;
  logic [AW-1:0] ws_r, ws_nxt;
  logic [CW-1:0] wc_r, wc_nxt;

  // Pipeline.
  s1_t           s1_r, s1_nxt;
  logic          s1_valid_r;
  logic          fwd_hit_r;
  logic [7:0]    fwd_data_r;
  logic [15:0]   sw_r, sw_nxt;
  logic          out_valid_r;
  logic [47:0]   out_data_r;

  // Handshake.
  logic adv, in_fire;
  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;
  assign in_fire   = in_tvalid && adv;

  // Input fields.
  cmd_t        cmd;
  logic [7:0]  bus_d;
  logic [11:0] idx;
  logic        idx_ok;
  assign cmd    = cmd_t'(in_tdata[2:0]);
  assign bus_d  = in_tdata[10:3];
  assign idx    = in_tdata[22:11];
  assign idx_ok = {1'b0, idx} < IDX_END;

  // RAM ports.
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;
  logic          s2_we;
  logic [7:0]    s2_wdata;
  logic [7:0]    mem_rd;
  logic [7:0]    s2_rd;

  fsbc_ram #(
    .WIDTH (8),
    .DEPTH (TRACK_BYTES)
  ) u_track_ram (
    .clk   (clk),
    .we    (s2_we),
    .waddr (s1_r.waddr),
    .wdata (s2_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ---------------- Stage 1: control state, RAM read issue ----------------
  always_comb begin
    logic [1:0]     drive;
    logic [HW-1:0]  cur;
    logic [HW+5:0]  trk_ext;
    logic [AW+11:0] ws_ext;
    logic [CW+11:0] wc_ext;
    logic           reload;

    ht_nxt    = ht_r;
    sel_nxt   = sel_r;
    prev_nxt  = prev_r;
    bl_nxt    = bl_r;
    ep_nxt    = ep_r;
    rdy_nxt   = rdy_r;
    bp_nxt    = bp_r;
    ws_nxt    = ws_r;
    wc_nxt    = wc_r;
    ram_re    = 1'b0;
    ram_raddr = bp_r;
    drive     = SEL_NONE;
    cur       = '0;
    reload    = 1'b0;
    trk_ext   = '0;
    ws_ext    = '0;
    wc_ext    = '0;

    s1_nxt          = '0;
    s1_nxt.rd_sel   = RD_CONST;
    s1_nxt.rd_const = BUS_IDLE;
    s1_nxt.sw_op    = SW_KEEP;

    if (in_fire) begin
      case (cmd)
        CMD_LATCH: begin
          drive = bus_d[LATCH_SEL0] ? SEL_DRIVE0 :
                  bus_d[LATCH_SEL1] ? SEL_DRIVE1 : SEL_NONE;
          if (drive != sel_r) begin
            sel_nxt = drive;
            if (drive != SEL_NONE) begin
              reload = 1'b1;
              bp_nxt = '0;
              wc_nxt = '0;
            end
          end
          if (sel_nxt != SEL_NONE) begin
            cur = ht_r[sel_nxt[0]];
            if (stepped(bus_d, prev_r, DIR_OUT)) begin
              if (cur != '0) cur = cur - 1'b1;
              if (!cur[0]) begin
                reload = 1'b1;
                bp_nxt = '0;
                wc_nxt = '0;
              end
            end else if (stepped(bus_d, prev_r, DIR_IN)) begin
              if (cur != HT_MAX) cur = cur + 1'b1;
              if (!cur[0]) begin
                reload = 1'b1;
                bp_nxt = '0;
                wc_nxt = '0;
              end
            end
            ht_nxt[sel_nxt[0]] = cur;

            // Write gate low: shift in one flux bit, count bit cells.
            if (!bus_d[LATCH_GATE]) begin
              s1_nxt.sw_op = SW_SHIFT;
              s1_nxt.flux  = prev_r[LATCH_FLUX] ^ bus_d[LATCH_FLUX];
              ep_nxt       = ~ep_r;
              if (!ep_nxt && bl_nxt != '0) begin
                bl_nxt = bl_nxt - 1'b1;
                if (bl_nxt == '0) begin
                  s1_nxt.mem_we      = 1'b1;
                  s1_nxt.wsrc_decode = 1'b1;
                  s1_nxt.waddr       = bp_nxt;
                  bp_nxt = (bp_nxt == BP_LAST) ? '0 : bp_nxt + 1'b1;
                  if (wc_nxt != WC_FULL) wc_nxt = wc_nxt + 1'b1;
                  bl_nxt = BITS_PER_BYTE;
                end
              end
            end

            // Write gate edge: falling starts a run, rising ends it.
            if (prev_r[LATCH_GATE] ^ bus_d[LATCH_GATE]) begin
              if (prev_r[LATCH_GATE]) begin
                ws_nxt = bp_nxt;
                ep_nxt = 1'b0;
              end else if (wc_nxt != '0) begin
                s1_nxt.store = 1'b1;
                ws_ext = {12'b0, ws_r};
                wc_ext = {12'b0, wc_nxt};
                s1_nxt.store_start = ws_ext[11:0];
                s1_nxt.store_count = wc_ext[11:0];
              end
              bl_nxt = BITS_PER_BYTE;
              wc_nxt = '0;
            end

            s1_nxt.load = reload;
            if (reload || s1_nxt.store) begin
              trk_ext = {6'b0, cur};
              s1_nxt.req_drive = sel_nxt[0];
              s1_nxt.req_track = trk_ext[6:1];
            end
          end
          prev_nxt = bus_d;
        end

        CMD_DATA_RD: begin
          if (bl_r != '0) begin
            if (rdy_r) bl_nxt = bl_r - 1'b1;
            s1_nxt.rd_sel = RD_SHIFT;
            s1_nxt.shamt  = bl_nxt;
          end
          if (bl_nxt == '0) begin
            s1_nxt.sw_op = SW_LOAD;
            ram_re    = 1'b1;
            ram_raddr = bp_r;
            if (rdy_r) begin
              bl_nxt = BITS_PER_BYTE;
              bp_nxt = (bp_r == BP_LAST) ? '0 : bp_r + 1'b1;
            end
            rdy_nxt = 1'b0;
          end
        end

        CMD_POLL: begin
          if (sel_r != SEL_NONE) rdy_nxt = 1'b1;
          s1_nxt.rd_const = rdy_nxt ? FLAG_SET : FLAG_CLEAR;
        end

        CMD_PROTECT: begin
          if (sel_r == SEL_DRIVE0) begin
            s1_nxt.rd_const = prot0_r ? FLAG_SET : FLAG_CLEAR;
          end else if (sel_r == SEL_DRIVE1) begin
            s1_nxt.rd_const = prot1_r ? FLAG_SET : FLAG_CLEAR;
          end
        end

        CMD_HOST_LOAD: begin
          if (idx_ok) begin
            s1_nxt.mem_we    = 1'b1;
            s1_nxt.waddr     = idx[AW-1:0];
            s1_nxt.host_byte = bus_d;
          end
        end

        CMD_HOST_READ: begin
          if (idx_ok) begin
            ram_re        = 1'b1;
            ram_raddr     = idx[AW-1:0];
            s1_nxt.rd_sel = RD_MEM;
          end
        end

        default: begin
        end
      endcase
    end
  end

  // ---------------- Stage 2: shift word, buffer write, result ----------------
  assign mem_rd = fwd_hit_r ? fwd_data_r : ram_rdata;
  assign s2_we  = s1_valid_r && adv && s1_r.mem_we;

  always_comb begin
    logic [15:0] shifted;
    shifted = sw_r >> s1_r.shamt;
    case (s1_r.sw_op)
      SW_SHIFT: sw_nxt = {sw_r[14:0], s1_r.flux};
      SW_LOAD:  sw_nxt = {8'b0, mem_rd};
      default:  sw_nxt = sw_r;
    endcase
    case (s1_r.rd_sel)
      RD_MEM:   s2_rd = mem_rd;
      RD_SHIFT: s2_rd = shifted[7:0];
      default:  s2_rd = s1_r.rd_const;
    endcase
    s2_wdata = s1_r.wsrc_decode ? decode_cells(sw_nxt) : s1_r.host_byte;
  end

  // ---------------- Registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prot0_r     <= 1'b1;
      prot1_r     <= 1'b1;
      ht_r[0]     <= HT_MAX;
      ht_r[1]     <= HT_MAX;
      sel_r       <= SEL_NONE;
      prev_r      <= '0;
      bl_r        <= BITS_PER_BYTE;
      ep_r        <= 1'b0;
      rdy_r       <= 1'b0;
      bp_r        <= '0;
      ws_r        <= '0;
      wc_r        <= '0;
      sw_r        <= '0;
      s1_valid_r  <= 1'b0;
      fwd_hit_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index) prot1_r <= cfg_data;
        else           prot0_r <= cfg_data;
      end
      ht_r   <= ht_nxt;
      sel_r  <= sel_nxt;
      prev_r <= prev_nxt;
      bl_r   <= bl_nxt;
      ep_r   <= ep_nxt;
      rdy_r  <= rdy_nxt;
      bp_r   <= bp_nxt;
      ws_r   <= ws_nxt;
      wc_r   <= wc_nxt;
      if (adv) begin
        s1_valid_r  <= in_fire;
        out_valid_r <= s1_valid_r;
        if (s1_valid_r) sw_r <= sw_nxt;
      end
      // Buffer write in stage 2 this cycle hits the entry read now.
      if (in_fire) begin
        fwd_hit_r <= s2_we && (s1_r.waddr == ram_raddr);
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      fwd_data_r <= s2_wdata;
    end
    if (adv) begin
      s1_r       <= s1_nxt;
      out_data_r <= {7'b0, s1_r.store_count, s1_r.store_start, s1_r.req_track,
                     s1_r.req_drive, s1_r.store, s1_r.load, s2_rd};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // ---------------- Assertions ----------------
  a_bits_left_range: assert property (@(posedge clk) disable iff (!rst_n)
    bl_r <= BITS_PER_BYTE)
    else $error("bit counter out of range");

  a_half_track_range: assert property (@(posedge clk) disable iff (!rst_n)
    (ht_r[0] <= HT_MAX) && (ht_r[1] <= HT_MAX))
    else $error("half-track beyond limit");

  a_no_load_with_store: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> !(s1_r.load && s1_r.store))
    else $error("load and store requested together");

  a_stage1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !adv) |=> (s1_valid_r && $stable(s1_r) && $stable(fwd_hit_r)))
    else $error("stage 1 lost its request during a stall");

endmodule

>>> tb/floppy_stepper_and_bit_controller_tb.sv
// Self-checking bench for the floppy stepper and bit controller: bus requests in,
// one result per request out, compared with an in-bench behavioral predictor.
// Depends on fsbc_pkg and the floppy_stepper_and_bit_controller RTL only.
`timescale 1ns / 100ps

module floppy_stepper_and_bit_controller_tb;
  import fsbc_pkg::*;

  localparam int TRACK_BYTES    = 3172;
  localparam int MAX_HALF_TRACK = 80;
  localparam int SAT_BYTES      = 3180;   // one run long enough to saturate the count
  localparam int HOLD_LIMIT     = 5000;   // cycles without any handshake
  localparam int SETTLE_CYCLES  = 10;     // pipe is two deep, plenty of margin
  localparam int MAX_REPORTS    = 50;
  localparam int MIX_ITEMS      = 240;    // random requests per idling phase

  // Spare command codes, not decoded by the block.
  localparam logic [2:0] CMD_RSVD6 = 3'd6;
  localparam logic [2:0] CMD_RSVD7 = 3'd7;

  // Config register indexes.
  localparam logic REG_PROTECT0 = 1'b0;
  localparam logic REG_PROTECT1 = 1'b1;

  // Result layout, lowest bits last, matching out_tdata[40:0].
  typedef struct packed {
    logic [11:0] store_count;
    logic [11:0] store_start;
    logic [5:0]  req_track;
    logic        req_drive;
    logic        store_req;
    logic        load_req;
    logic [7:0]  read_data;
  } bus_result_t;

  typedef struct {
    logic [2:0]  cmd;
    logic [7:0]  bus;
    logic [11:0] idx;
    bit          typed;     // read_data given below, all other fields zero
    logic [7:0]  want_rd;
  } script_row_t;

  logic        clk;
  logic        rst_n;
  logic [23:0] in_tdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] out_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic        cfg_we;
  logic        cfg_index;
  logic        cfg_data;

  floppy_stepper_and_bit_controller DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: mirrors the controller as seen through the bus.
  // ---------------------------------------------------------------------------
  logic        prot_bit [2];
  logic [6:0]  half_trk [2];
  logic [1:0]  sel_drv;
  logic [7:0]  prev_latch;
  logic [15:0] shift_w;
  logic [3:0]  bits_rem;
  logic        cell_phase;
  logic        ready;
  int unsigned byte_pos;
  int unsigned run_start;
  int unsigned run_len;
  logic [7:0]  trk_mem [TRACK_BYTES];

  bus_result_t pending_results [$];
  int          sent_count;
  int          err_count;
  int          gap_pct;
  int          stall_pct;
  int          quiet_cycles;

  // Directed requests. Typed rows are the ones whose answer is obvious:
  // reset state, spare codes, host accesses in and out of range, protect/poll flags.
  script_row_t script [22] = '{
    '{CMD_RSVD6,     8'hff, 12'hfff, 1'b1, BUS_IDLE},    // spare code
    '{CMD_RSVD7,     8'h00, 12'h000, 1'b1, BUS_IDLE},    // spare code
    '{CMD_PROTECT,   8'h00, 12'h000, 1'b1, BUS_IDLE},    // no drive selected
    '{CMD_POLL,      8'h00, 12'h000, 1'b1, FLAG_CLEAR},  // no drive: flag stays low
    '{CMD_DATA_RD,   8'h00, 12'h000, 1'b1, 8'h00},       // no drive, shift word clear
    '{CMD_HOST_READ, 8'h00, 12'hfff, 1'b1, BUS_IDLE},    // index past the buffer
    '{CMD_HOST_LOAD, 8'h77, 12'd3172, 1'b1, BUS_IDLE},   // ignored, past the buffer
    '{CMD_HOST_LOAD, 8'ha5, 12'd0,    1'b1, BUS_IDLE},
    '{CMD_HOST_LOAD, 8'h5a, 12'd3171, 1'b1, BUS_IDLE},
    '{CMD_HOST_READ, 8'h00, 12'd0,    1'b1, 8'ha5},
    '{CMD_HOST_READ, 8'h00, 12'd3171, 1'b1, 8'h5a},
    '{CMD_LATCH,     8'h2f, 12'h000, 1'b1, BUS_IDLE},    // no drive: latch only
    '{CMD_LATCH,     8'h51, 12'h000, 1'b0, 8'h00},       // select 0, step out
    '{CMD_PROTECT,   8'h00, 12'h000, 1'b1, FLAG_SET},    // drive 0 protected at reset
    '{CMD_LATCH,     8'h52, 12'h000, 1'b0, 8'h00},       // step in to even track
    '{CMD_LATCH,     8'h54, 12'h000, 1'b0, 8'h00},       // step in, held at the limit
    '{CMD_LATCH,     8'hc0, 12'h000, 1'b0, 8'h00},       // select 1
    '{CMD_PROTECT,   8'h00, 12'h000, 1'b1, FLAG_SET},    // drive 1 protected at reset
    '{CMD_POLL,      8'h00, 12'h000, 1'b1, FLAG_SET},    // drive selected: ready
    '{CMD_DATA_RD,   8'h00, 12'h000, 1'b0, 8'h00},       // one bit out, no refill yet
    '{CMD_LATCH,     8'h00, 12'h000, 1'b0, 8'h00},       // deselect
    '{CMD_LATCH,     8'h90, 12'h000, 1'b0, 8'h00}        // both selects: drive 0 wins
  };

  // Step detect: the only phase on now sits dir below a phase that was on.
  function automatic bit phase_step(input logic [7:0] now, input logic [7:0] prev,
                                    input logic [1:0] dir);
    logic [7:0] twice;
    logic [3:0] rot;
    twice = {prev[3:0], prev[3:0]};
    rot   = 4'(twice >> dir);
    return (now[3:0] != 4'h0) && ((now[3:0] & (now[3:0] - 4'h1)) == 4'h0) &&
           ((now[3:0] & rot) != 4'h0);
  endfunction

  // Data bits live in every other flux cell.
  function automatic logic [7:0] cells_to_byte(input logic [15:0] w);
    logic [7:0] v;
    for (int k = 0; k < 8; k++) v[k] = w[k * 2];
    return v;
  endfunction

  // One bus access against the predictor; returns the result it must produce.
  function automatic bus_result_t bus_access(input logic [2:0] cmd, input logic [7:0] d,
                                             input logic [11:0] idx);
    bus_result_t r;
    logic [1:0]  drv;
    logic        reload;
    logic        store;
    int unsigned st;
    int unsigned cnt;
    r = '0;
    r.read_data = BUS_IDLE;
    reload = 1'b0;
    store = 1'b0;
    st = 0;
    cnt = 0;
    case (cmd)
      CMD_LATCH: begin
        drv = d[LATCH_SEL0] ? SEL_DRIVE0 : (d[LATCH_SEL1] ? SEL_DRIVE1 : SEL_NONE);
        if (drv != sel_drv) begin
          sel_drv = drv;
          reload = (drv != SEL_NONE);
        end
        if (sel_drv != SEL_NONE) begin
          if (phase_step(d, prev_latch, DIR_OUT)) begin
            if (half_trk[sel_drv[0]] != 7'd0) half_trk[sel_drv[0]] = half_trk[sel_drv[0]] - 7'd1;
            if (!half_trk[sel_drv[0]][0]) reload = 1'b1;
          end else if (phase_step(d, prev_latch, DIR_IN)) begin
            if (half_trk[sel_drv[0]] < MAX_HALF_TRACK)
              half_trk[sel_drv[0]] = half_trk[sel_drv[0]] + 7'd1;
            if (!half_trk[sel_drv[0]][0]) reload = 1'b1;
          end
          // track reload restarts the buffer walk and drops the run
          if (reload) begin
            byte_pos = 0;
            run_len = 0;
          end
          if (!d[LATCH_GATE]) begin
            shift_w = {shift_w[14:0], prev_latch[LATCH_FLUX] ^ d[LATCH_FLUX]};
            cell_phase = ~cell_phase;
            if (!cell_phase && bits_rem != 4'd0) begin
              bits_rem = bits_rem - 4'd1;
              if (bits_rem == 4'd0) begin
                trk_mem[byte_pos] = cells_to_byte(shift_w);
                byte_pos = (byte_pos + 1) % TRACK_BYTES;
                if (run_len < TRACK_BYTES) run_len++;
                bits_rem = BITS_PER_BYTE;
              end
            end
          end
          if (prev_latch[LATCH_GATE] != d[LATCH_GATE]) begin
            if (prev_latch[LATCH_GATE]) begin
              run_start = byte_pos;
              cell_phase = 1'b0;
            end else if (run_len != 0) begin
              store = 1'b1;
              st = run_start;
              cnt = run_len;
            end
            bits_rem = BITS_PER_BYTE;
            run_len = 0;
          end
        end
        prev_latch = d;
      end
      CMD_DATA_RD: begin
        if (bits_rem != 4'd0) begin
          if (ready) bits_rem = bits_rem - 4'd1;
          r.read_data = 8'(shift_w >> bits_rem);
        end
        if (bits_rem == 4'd0) begin
          shift_w = {8'h00, trk_mem[byte_pos]};
          if (ready) begin
            bits_rem = BITS_PER_BYTE;
            byte_pos = (byte_pos + 1) % TRACK_BYTES;
          end
          ready = 1'b0;
        end
      end
      CMD_POLL: begin
        if (sel_drv != SEL_NONE) ready = 1'b1;
        r.read_data = ready ? FLAG_SET : FLAG_CLEAR;
      end
      CMD_PROTECT: begin
        if (sel_drv != SEL_NONE) r.read_data = prot_bit[sel_drv[0]] ? FLAG_SET : FLAG_CLEAR;
      end
      CMD_HOST_LOAD: begin
        if (idx < TRACK_BYTES) trk_mem[idx] = d;
      end
      CMD_HOST_READ: begin
        if (idx < TRACK_BYTES) r.read_data = trk_mem[idx];
      end
      default: ;
    endcase
    r.load_req = reload;
    r.store_req = store;
    if ((reload || store) && sel_drv != SEL_NONE) begin
      r.req_drive = sel_drv[0];
      r.req_track = 6'(half_trk[sel_drv[0]] >> 1);
    end
    if (store) begin
      r.store_start = 12'(st);
      r.store_count = 12'(cnt);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, receiver stalls, result checking, watchdog.
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) out_tready <= ($urandom_range(99) >= stall_pct);

  task automatic flag_mismatch(input string what, input logic [11:0] want,
                               input logic [11:0] got);
    err_count++;
    if (err_count <= MAX_REPORTS)
      $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
  endtask

  task automatic cmp_field(input string what, input logic [11:0] want,
                           input logic [11:0] got);
    if (got !== want) flag_mismatch(what, want, got);
  endtask

  // Inputs only move at rising edges, so the values seen at the falling edge
  // are the ones the next rising edge will take.
  always @(negedge clk) begin : result_check
    bus_result_t got;
    bus_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = bus_result_t'(out_tdata[40:0]);
      if (pending_results.size() == 0) begin
        flag_mismatch("unexpected result, read_data", 12'h0, 12'(got.read_data));
      end else begin
        want = pending_results.pop_front();
        cmp_field("read_data",     12'(want.read_data), 12'(got.read_data));
        cmp_field("load_request",  12'(want.load_req),  12'(got.load_req));
        cmp_field("store_request", 12'(want.store_req), 12'(got.store_req));
        cmp_field("request_drive", 12'(want.req_drive), 12'(got.req_drive));
        cmp_field("request_track", 12'(want.req_track), 12'(got.req_track));
        cmp_field("store_start",   want.store_start,    got.store_start);
        cmp_field("store_count",   want.store_count,    got.store_count);
      end
    end
  end

  always @(negedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= HOLD_LIMIT) begin
        $display("[floppy_stepper_and_bit_controller] ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request driving.
  // ---------------------------------------------------------------------------
  // Present one request, with random leading gaps, and hold it until taken.
  task automatic send_access(input logic [2:0] cmd, input logic [7:0] bus,
                             input logic [11:0] idx, input bit typed = 1'b0,
                             input logic [7:0] want_rd = 8'h00);
    bus_result_t model;
    bus_result_t want;
    bit          took;
    while ($urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tdata  <= {1'b0, idx, bus, cmd};
    in_tvalid <= 1'b1;
    do begin
      @(negedge clk);
      took = in_tready;
      @(posedge clk);
    end while (!took);
    model = bus_access(cmd, bus, idx);
    if (typed) begin
      want = '0;
      want.read_data = want_rd;
      pending_results.push_back(want);
    end else begin
      pending_results.push_back(model);
    end
    sent_count++;
  endtask

  // Stop sending and wait until every result is back; returns on a rising edge.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // Config writes only with the pipe empty.
  task automatic write_protect(input logic which, input logic val);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= which;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    prot_bit[which] = val;
  endtask

  // Latch byte for a drive; drive 0 sometimes also carries the drive 1 select.
  function automatic logic [7:0] latch_val(input bit drv1, input bit gate,
                                           input logic [3:0] ph);
    logic [7:0] v;
    v = '0;
    v[LATCH_SEL0] = !drv1;
    v[LATCH_SEL1] = drv1 | 1'($urandom_range(1));
    v[LATCH_GATE] = gate;
    v[LATCH_FLUX] = 1'($urandom_range(1));
    v[3:0] = ph;
    return v;
  endfunction

  // Gate low for a number of flux cells, then gate high to close the run.
  // Unless steady, a few writes carry a phase and some runs swap drives halfway.
  task automatic write_run(input bit drv1, input int cells, input bit steady);
    bit         cur;
    bit         flip;
    logic [3:0] ph;
    cur  = drv1;
    flip = !steady && ($urandom_range(7) == 0);
    send_access(CMD_LATCH, latch_val(cur, 1'b1, 4'h0), 12'($urandom_range(4095)));
    for (int i = 0; i < cells; i++) begin
      if (flip && i == cells / 2) cur = !cur;
      ph = (!steady && $urandom_range(15) == 0) ? (4'b0001 << $urandom_range(3)) : 4'h0;
      send_access(CMD_LATCH, latch_val(cur, 1'b0, ph), 12'($urandom_range(4095)));
    end
    send_access(CMD_LATCH, latch_val(cur, 1'b1, 4'h0), 12'($urandom_range(4095)));
  endtask

  // Rotate the stepper phases; now and then a random pattern of phases instead.
  task automatic step_run(input bit drv1, input bit inward, input int len);
    logic [1:0] n;
    logic [3:0] ph;
    n = 2'($urandom_range(3));
    for (int i = 0; i < len; i++) begin
      n = inward ? n + 2'd1 : n - 2'd1;
      ph = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : (4'b0001 << n);
      send_access(CMD_LATCH, latch_val(drv1, $urandom_range(3) != 0, ph),
                  12'($urandom_range(4095)));
    end
  endtask

  // Poll, then clock bits out of the data port, with other reads mixed in.
  task automatic read_burst();
    int k;
    if ($urandom_range(1))
      send_access(CMD_LATCH, latch_val($urandom_range(1), 1'b1, 4'h0),
                  12'($urandom_range(4095)));
    send_access(CMD_POLL, 8'($urandom_range(255)), 12'($urandom_range(4095)));
    k = $urandom_range(12, 1);
    for (int i = 0; i < k; i++) begin
      case ($urandom_range(9))
        0: send_access(CMD_POLL, 8'($urandom_range(255)), 12'($urandom_range(4095)));
        1: send_access(CMD_PROTECT, 8'($urandom_range(255)), 12'($urandom_range(4095)));
        default: send_access(CMD_DATA_RD, 8'($urandom_range(255)), 12'($urandom_range(4095)));
      endcase
    end
  endtask

  task automatic run_mix(input int target);
    int base;
    int pick;
    bit paused;
    logic [11:0] idx;
    base = sent_count;
    paused = 1'b0;
    while (sent_count - base < target) begin
      // once per phase the sender holds off until the pipe is empty
      if (!paused && sent_count - base >= target / 2) begin
        drain_results();
        paused = 1'b1;
      end
      pick = $urandom_range(99);
      idx = ($urandom_range(7) == 0) ? 12'($urandom_range(4095, TRACK_BYTES))
                                     : 12'($urandom_range(TRACK_BYTES - 1));
      if (pick < 40) begin
        write_run($urandom_range(1),
                  ($urandom_range(3) == 0) ? int'($urandom_range(15))
                                           : int'(16 * $urandom_range(3, 1) + $urandom_range(3)),
                  1'b0);
      end else if (pick < 58) begin
        read_burst();
      end else if (pick < 72) begin
        step_run($urandom_range(1), $urandom_range(1),
                 ($urandom_range(4) == 0) ? 90 : int'($urandom_range(12, 1)));
      end else if (pick < 82) begin
        send_access($urandom_range(1) ? CMD_HOST_LOAD : CMD_HOST_READ,
                    8'($urandom_range(255)), idx);
      end else begin
        send_access(3'($urandom_range(7)), 8'($urandom_range(255)),
                    12'($urandom_range(4095)));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    rst_n      = 1'b0;
    in_tdata   = '0;
    in_tvalid  = 1'b0;
    out_tready = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = 1'b0;
    cfg_data   = 1'b0;
    gap_pct    = 0;
    stall_pct  = 0;
    sent_count = 0;
    err_count  = 0;
    quiet_cycles = 0;
    prot_bit   = '{1'b1, 1'b1};
    half_trk   = '{7'(MAX_HALF_TRACK), 7'(MAX_HALF_TRACK)};
    sel_drv    = SEL_NONE;
    prev_latch = 8'h00;
    shift_w    = 16'h0000;
    bits_rem   = BITS_PER_BYTE;
    cell_phase = 1'b0;
    ready      = 1'b0;
    byte_pos   = 0;
    run_start  = 0;
    run_len    = 0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed requests touch no buffer entry that was not loaded first.
    foreach (script[i])
      send_access(script[i].cmd, script[i].bus, script[i].idx, script[i].typed,
                  script[i].want_rd);

    // Fill the whole track buffer so later data reads never see unwritten bytes.
    for (int i = 0; i < TRACK_BYTES; i++)
      send_access(CMD_HOST_LOAD, 8'($urandom_range(255)), 12'(i));

    // Four idling phases, each with its own protect setting.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 63; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 63; end
        default: begin gap_pct = 33; stall_pct = 33; end
      endcase
      write_protect(REG_PROTECT0, ph[0]);
      write_protect(REG_PROTECT1, ph[1]);
      // one run past the buffer size: count saturates, position wraps
      if (ph == 0) write_run(1'b0, 16 * SAT_BYTES + 5, 1'b1);
      run_mix(MIX_ITEMS);
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("[floppy_stepper_and_bit_controller] OK");
    end else begin
      $display("[floppy_stepper_and_bit_controller] ERROR");
    end
    $finish;
  end

endmodule
